// ===== rtl/core/min_plus_shortest_paths_defines.svh =====
// Assertion macros shared by the shortest path block.
`ifndef MIN_PLUS_SHORTEST_PATHS_DEFINES_SVH
`define MIN_PLUS_SHORTEST_PATHS_DEFINES_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
`define MSP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define MSP_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define MSP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/core/msp_pkg.sv =====
`default_nettype none

package msp_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int COST_BITS_DEF = 16;
    localparam logic [4:0] NODE_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic init;
        logic pred;
        logic copy;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/msp_in_if.sv =====
`default_nettype none

interface msp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  src_node;
    logic [3:0]  dst_node;
    logic        edge_present;
    logic [15:0] edge_cost;

    modport source (output valid, func, src_node, dst_node, edge_present, edge_cost,
                    input ready);
    modport sink (input valid, func, src_node, dst_node, edge_present, edge_cost,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msp_out_if.sv =====
`default_nettype none

interface msp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance;
    logic [4:0]  predecessor;

    modport source (output valid, distance, predecessor, input ready);
    modport sink (input valid, distance, predecessor, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msp_cell.sv =====
`default_nettype none

module msp_cell
    import msp_pkg::*;
#(
    parameter int MaxNodes = MAX_NODES_DEF,
    parameter int CostBits = COST_BITS_DEF,
    parameter int CellIdx = 0,
    localparam int IW = $clog2(MaxNodes),
    localparam int NW = $clog2(MaxNodes + 1)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [NW-1:0]       n_act,
    input  wire logic                cost_we,
    input  wire logic [IW-1:0]       cost_row,
    input  wire logic [IW-1:0]       cost_col,
    input  wire logic [CostBits-1:0] cost_wdata,
    input  wire logic                wr_en,
    input  wire logic [IW-1:0]       wr_i,
    input  wire logic [IW-1:0]       wr_j,
    input  wire logic [CostBits-1:0] wr_d,
    input  wire logic [NW-1:0]       wr_p,
    input  wire logic [IW-1:0]       rd_j,
    output logic [CostBits-1:0]      rd_cost,
    output logic [CostBits-1:0]      rd_dist,
    output logic [NW-1:0]            rd_pred,
    input  wire logic                vld_in,
    input  wire logic [IW-1:0]       i_in,
    input  wire logic [IW-1:0]       j_in,
    input  wire logic [CostBits-1:0] val_in,
    input  wire logic [NW-1:0]       p_in,
    input  wire logic                chk_in,
    output logic                     vld_out,
    output logic [IW-1:0]            i_out,
    output logic [IW-1:0]            j_out,
    output logic [CostBits-1:0]      val_out,
    output logic [NW-1:0]            p_out,
    output logic                     chk_out
);

    localparam logic [CostBits-1:0] INF = '1;
    localparam logic [NW-1:0] PRED_NONE = NW'(MaxNodes);
    localparam logic [IW-1:0] MY_IDX = IW'(CellIdx);

    logic [CostBits-1:0] row_cur [MaxNodes];
    logic [CostBits-1:0] row_nxt [MaxNodes];
    logic [CostBits-1:0] col_cur [MaxNodes];
    logic [CostBits-1:0] col_nxt [MaxNodes];
    logic [CostBits-1:0] dist_q [MaxNodes];
    logic [NW-1:0]       pred_row [MaxNodes];
    logic [CostBits-1:0] cost_a [MaxNodes];
    logic [CostBits-1:0] cost_b [MaxNodes];
    logic [MaxNodes-1:0] cost_vld_reg;

    logic                vld_reg;
    logic [IW-1:0]       i_reg;
    logic [IW-1:0]       j_reg;
    logic [CostBits-1:0] val_reg;
    logic [CostBits-1:0] val_next;
    logic [NW-1:0]       p_reg;
    logic [NW-1:0]       p_next;
    logic                chk_reg;

    logic [CostBits-1:0] op_a;
    logic [CostBits-1:0] op_b;
    logic [CostBits:0]   sum;
    logic [CostBits-1:0] sat;
    logic                active;
    logic                row_hit;
    logic                col_hit;

    assign active = (CellIdx < int'(n_act));
    assign op_a = col_cur[i_in];
    assign op_b = ctrl.pred ? (cost_vld_reg[j_in] ? cost_a[j_in] : INF) : row_cur[j_in];
    assign sum = {1'b0, op_a} + {1'b0, op_b};
    assign sat = (sum >= {1'b0, INF}) ? INF : sum[CostBits-1:0];

    always_comb
    begin
        val_next = val_in;
        p_next = p_in;
        if (ctrl.pred)
        begin
            if (active && chk_in && (j_in != MY_IDX) && (sat == val_in))
            begin
                p_next = NW'(CellIdx);
            end
        end
        else if (active && (sat < val_in))
        begin
            val_next = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_in;
        j_reg <= j_in;
        val_reg <= val_next;
        p_reg <= p_next;
        chk_reg <= chk_in;
    end

    assign vld_out = vld_reg;
    assign i_out = i_reg;
    assign j_out = j_reg;
    assign val_out = val_reg;
    assign p_out = p_reg;
    assign chk_out = chk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_vld_reg <= '0;
        end
        else if (cost_we && (cost_row == MY_IDX))
        begin
            cost_vld_reg[cost_col] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cost_we && (cost_row == MY_IDX))
        begin
            cost_a[cost_col] <= cost_wdata;
            cost_b[cost_col] <= cost_wdata;
        end
    end

    assign row_hit = wr_en && (wr_i == MY_IDX);
    assign col_hit = wr_en && (wr_j == MY_IDX);

    always_ff @(posedge clk)
    begin
        if (ctrl.copy)
        begin
            row_cur <= row_nxt;
            col_cur <= col_nxt;
            dist_q <= row_nxt;
        end
        else if (ctrl.init)
        begin
            if (row_hit)
            begin
                row_cur[wr_j] <= wr_d;
                row_nxt[wr_j] <= wr_d;
                dist_q[wr_j] <= wr_d;
                pred_row[wr_j] <= PRED_NONE;
            end
            if (col_hit)
            begin
                col_cur[wr_i] <= wr_d;
                col_nxt[wr_i] <= wr_d;
            end
        end
        else if (ctrl.pred)
        begin
            if (row_hit)
            begin
                pred_row[wr_j] <= wr_p;
            end
        end
        else
        begin
            if (row_hit)
            begin
                row_nxt[wr_j] <= wr_d;
            end
            if (col_hit)
            begin
                col_nxt[wr_i] <= wr_d;
            end
        end
    end

    assign rd_cost = cost_vld_reg[rd_j] ? cost_b[rd_j] : INF;
    assign rd_dist = dist_q[rd_j];
    assign rd_pred = pred_row[rd_j];

endmodule

`default_nettype wire

// ===== rtl/core/min_plus_shortest_paths.sv =====
// All-pairs shortest paths over a graph of up to MaxNodes nodes.
// Input channel req carries one transaction per item: a load writes one arc
// cost, a run computes all distances and predecessors, a query reads one pair.
// Output channel rsp carries one transaction per query with the distance and
// the predecessor; the result appears the cycle after the query is taken.
// A run first builds the start matrix over all MaxNodes*MaxNodes entries, then
// does ceil(log2(n-1)) min-plus squarings, then a predecessor pass, where n is
// the active node count. Every matrix entry of a squaring or predecessor pass
// goes through the row of MaxNodes add-compare cells, one cell after another.
// While a run is in progress req.ready is low. While a result is held for a
// stalled receiver, req.ready is also low and no transaction of any kind is taken.
// Reset empties the cost table (no arcs) and sets node_count to 16; distances
// and predecessors are undefined until the first run. The user writes node_count
// through cfg_we and cfg_wdata only while the block is idle; this is not enforced.
`default_nettype none

`include "min_plus_shortest_paths_defines.svh"

module min_plus_shortest_paths
    import msp_pkg::*;
#(
    parameter int MaxNodes = MAX_NODES_DEF,
    parameter int CostBits = COST_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    msp_in_if.sink          req,
    msp_out_if.source       rsp
);

    localparam int IW = $clog2(MaxNodes);
    localparam int NW = $clog2(MaxNodes + 1);
    localparam logic [CostBits-1:0] INF = '1;
    localparam logic [NW-1:0] PRED_NONE = NW'(MaxNodes);
    localparam logic [NW-1:0] LIM_FULL = NW'(MaxNodes);
    localparam logic [NW-1:0] DRAIN_LAST = NW'(MaxNodes - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_INIT     = 7'b0000010,
        ST_SQ_FEED  = 7'b0000100,
        ST_SQ_DRAIN = 7'b0001000,
        ST_COPY     = 7'b0010000,
        ST_PR_FEED  = 7'b0100000,
        ST_PR_DRAIN = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [4:0]    node_count_reg;
    logic [NW-1:0] n_reg, n_next;
    logic [NW:0]   m_reg, m_next;
    logic [NW-1:0] ci_reg, ci_next;
    logic [NW-1:0] cj_reg, cj_next;
    logic [NW-1:0] drain_reg, drain_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   dist_reg, dist_next;
    logic [4:0]    pred_reg, pred_next;

    logic          idle;
    logic          accept;
    logic          in_range;
    logic          run_last;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] lim;
    logic          last_pair;
    logic [CostBits:0] ext_cost;
    logic [CostBits-1:0] load_cost;
    cell_ctrl_t    ctrl;

    logic [IW-1:0] rd_i;
    logic [IW-1:0] rd_j;
    logic [CostBits-1:0] rd_cost_c [MaxNodes];
    logic [CostBits-1:0] rd_dist_c [MaxNodes];
    logic [NW-1:0]       rd_pred_c [MaxNodes];
    logic [CostBits-1:0] cost_sel;
    logic [CostBits-1:0] dist_sel;
    logic [NW-1:0]       pred_sel;
    logic [CostBits-1:0] init_val;

    logic                vld_c [MaxNodes+1];
    logic [IW-1:0]       i_c [MaxNodes+1];
    logic [IW-1:0]       j_c [MaxNodes+1];
    logic [CostBits-1:0] val_c [MaxNodes+1];
    logic [NW-1:0]       p_c [MaxNodes+1];
    logic                chk_c [MaxNodes+1];

    logic                wr_en;
    logic [IW-1:0]       wr_i;
    logic [IW-1:0]       wr_j;
    logic [CostBits-1:0] wr_d;

    assign idle = (state_reg == ST_IDLE);
    assign req.ready = idle && (!out_valid_reg || rsp.ready);
    assign accept = req.valid && req.ready;
    assign in_range = (int'(req.src_node) < MaxNodes) && (int'(req.dst_node) < MaxNodes);
    assign run_last = (state_reg == ST_PR_DRAIN) && (drain_reg == DRAIN_LAST);

    assign rsp.valid = out_valid_reg;
    assign rsp.distance = dist_reg;
    assign rsp.predecessor = pred_reg;

    always_comb
    begin
        if (node_count_reg == 5'd0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(node_count_reg) > MaxNodes)
        begin
            n_eff = LIM_FULL;
        end
        else
        begin
            n_eff = NW'(node_count_reg);
        end
    end

    assign ext_cost = (CostBits + 1)'(req.edge_cost);
    assign load_cost = !req.edge_present ? INF :
                       ((ext_cost >= {1'b0, INF}) ? (INF - 1'b1) : ext_cost[CostBits-1:0]);

    assign ctrl.init = (state_reg == ST_INIT);
    assign ctrl.pred = (state_reg == ST_PR_FEED) || (state_reg == ST_PR_DRAIN);
    assign ctrl.copy = (state_reg == ST_COPY);

    assign rd_i = idle ? IW'(req.src_node) : ci_reg[IW-1:0];
    assign rd_j = idle ? IW'(req.dst_node) : cj_reg[IW-1:0];
    assign cost_sel = rd_cost_c[rd_i];
    assign dist_sel = rd_dist_c[rd_i];
    assign pred_sel = rd_pred_c[rd_i];

    assign init_val = ((ci_reg < n_reg) && (cj_reg < n_reg)) ?
                      ((ci_reg == cj_reg) ? '0 : cost_sel) : INF;

    assign vld_c[0] = (state_reg == ST_SQ_FEED) || (state_reg == ST_PR_FEED);
    assign i_c[0] = ci_reg[IW-1:0];
    assign j_c[0] = cj_reg[IW-1:0];
    assign val_c[0] = ctrl.pred ? dist_sel : INF;
    assign p_c[0] = (cost_sel != INF) ? ci_reg : PRED_NONE;
    assign chk_c[0] = (ci_reg != cj_reg) && (dist_sel != INF);

    assign wr_en = ctrl.init || vld_c[MaxNodes];
    assign wr_i = ctrl.init ? ci_reg[IW-1:0] : i_c[MaxNodes];
    assign wr_j = ctrl.init ? cj_reg[IW-1:0] : j_c[MaxNodes];
    assign wr_d = ctrl.init ? init_val : val_c[MaxNodes];

    for (genvar k = 0; k < MaxNodes; k++)
    begin : g_cell
        msp_cell #(
            .MaxNodes(MaxNodes),
            .CostBits(CostBits),
            .CellIdx(k)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctrl(ctrl),
            .n_act(n_reg),
            .cost_we(accept && (req.func == FUNC_LOAD) && in_range),
            .cost_row(IW'(req.src_node)),
            .cost_col(IW'(req.dst_node)),
            .cost_wdata(load_cost),
            .wr_en(wr_en),
            .wr_i(wr_i),
            .wr_j(wr_j),
            .wr_d(wr_d),
            .wr_p(p_c[MaxNodes]),
            .rd_j(rd_j),
            .rd_cost(rd_cost_c[k]),
            .rd_dist(rd_dist_c[k]),
            .rd_pred(rd_pred_c[k]),
            .vld_in(vld_c[k]),
            .i_in(i_c[k]),
            .j_in(j_c[k]),
            .val_in(val_c[k]),
            .p_in(p_c[k]),
            .chk_in(chk_c[k]),
            .vld_out(vld_c[k+1]),
            .i_out(i_c[k+1]),
            .j_out(j_c[k+1]),
            .val_out(val_c[k+1]),
            .p_out(p_c[k+1]),
            .chk_out(chk_c[k+1])
        );
    end

    assign lim = ctrl.init ? LIM_FULL : n_reg;
    assign last_pair = (ci_reg == lim - 1'b1) && (cj_reg == lim - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        m_next = m_reg;
        ci_next = ci_reg;
        cj_next = cj_reg;
        drain_next = drain_reg;
        out_valid_next = out_valid_reg;
        dist_next = dist_reg;
        pred_next = pred_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if ((state_reg == ST_INIT) || (state_reg == ST_SQ_FEED) ||
            (state_reg == ST_PR_FEED))
        begin
            if (cj_reg == lim - 1'b1)
            begin
                cj_next = '0;
                ci_next = ci_reg + 1'b1;
            end
            else
            begin
                cj_next = cj_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_RUN:
                        begin
                            state_next = ST_INIT;
                            n_next = n_eff;
                            ci_next = '0;
                            cj_next = '0;
                        end
                        FUNC_QUERY:
                        begin
                            out_valid_next = 1'b1;
                            dist_next = in_range ? 16'(dist_sel) : 16'(INF);
                            pred_next = in_range ? 5'(pred_sel) : 5'(PRED_NONE);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                if (last_pair)
                begin
                    m_next = (NW+1)'(1);
                    ci_next = '0;
                    cj_next = '0;
                    state_next = ((NW+1)'(2) < {1'b0, n_reg}) ? ST_SQ_FEED : ST_PR_FEED;
                end
            end
            ST_SQ_FEED:
            begin
                if (last_pair)
                begin
                    drain_next = '0;
                    state_next = ST_SQ_DRAIN;
                end
            end
            ST_SQ_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                m_next = m_reg << 1;
                ci_next = '0;
                cj_next = '0;
                state_next = ((m_next + 1'b1) < {1'b0, n_reg}) ? ST_SQ_FEED : ST_PR_FEED;
            end
            ST_PR_FEED:
            begin
                if (last_pair)
                begin
                    drain_next = '0;
                    state_next = ST_PR_DRAIN;
                end
            end
            ST_PR_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            n_reg <= LIM_FULL;
            m_reg <= '0;
            ci_reg <= '0;
            cj_reg <= '0;
            drain_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            n_reg <= n_next;
            m_reg <= m_next;
            ci_reg <= ci_next;
            cj_reg <= cj_next;
            drain_reg <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        pred_reg <= pred_next;
    end

    // A busy sequencer must hold off new transactions.
    `MSP_ASSERT_IMPL(a_busy_blocks_input, clk, rst_n, state_reg != ST_IDLE, !req.ready)
    // Results leave the cell row only while a squaring or predecessor pass runs.
    `MSP_ASSERT_IMPL(a_chain_write_in_run, clk, rst_n, vld_c[MaxNodes], !(idle || ctrl.init || ctrl.copy))
    // The bank copy happens only after the cell row has fully drained.
    `MSP_ASSERT_IMPL(a_copy_after_drain, clk, rst_n, state_reg == ST_COPY, !vld_c[MaxNodes])
    // A completed run leaves the sequencer idle with an empty cell row.
    `MSP_ASSERT_NEXT(a_run_ends_clean, clk, rst_n, run_last, idle && !vld_c[MaxNodes])

endmodule

`default_nettype wire
